### hw/rtl/ccwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_pkg
// Shared constants, types and controller/datapath interface structs for the
// coin change way counter.
// ----------------------------------------------------------------------------
package ccwc_pkg;

  localparam int MAX_TARGET = 1023;
  localparam int TABLE_DEPTH = MAX_TARGET + 1;
  localparam int AMT_W = 10;
  localparam int NUM_COINS = 8;
  localparam int COIN_IDX_W = 3;
  localparam int COIN_CNT_W = COIN_IDX_W + 1;
  localparam int ENTRY_W = 64;
  localparam int COUNT_W = ENTRY_W - 1;

  typedef logic [AMT_W-1:0] amt_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam amt_t COIN_RESET [NUM_COINS] = '{
    10'd1, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd200
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SELECT,
    S_RUN,
    S_FETCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic load_target;
    logic clr_en;
    logic pass_init;
    logic next_coin;
    logic run_en;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_at_target;
    logic coin_done;
    logic coin_skip;
  } ctl_sts_t;

endpackage

### hw/rtl/ccwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ccwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ccwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_ctrl
// Request sequencer: clear sweep, one update pass per coin not skipped, result fetch.
// ----------------------------------------------------------------------------
module ccwc_ctrl import ccwc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (sts.cnt_at_target) begin
          state_next = S_SELECT;
        end
      end
      S_SELECT: begin
        if (sts.coin_done) begin
          state_next = S_FETCH;
        end else if (!sts.coin_skip) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.cnt_at_target) begin
          state_next = S_SELECT;
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_target = in_valid;
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      S_SELECT: begin
        cmd.next_coin = !sts.coin_done && sts.coin_skip;
        cmd.pass_init = !sts.coin_done && !sts.coin_skip;
      end
      S_RUN: begin
        cmd.run_en    = 1'b1;
        cmd.next_coin = sts.cnt_at_target;
      end
      S_LOAD: begin
        cmd.load_result = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  a_accept_starts_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CLEAR))
    else $error("accepted word did not start the clear sweep");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

### hw/rtl/ccwc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_datapath
// Coin registers, sweep counter, two-copy way table and saturating update.
// ----------------------------------------------------------------------------
module ccwc_datapath import ccwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [COIN_IDX_W-1:0] cfg_index,
  input  logic [AMT_W-1:0]      cfg_data,
  input  logic [AMT_W-1:0]      target_amount,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  output logic [COUNT_W-1:0]    ways_count,
  output logic                  count_overflow
);

  amt_t                  coin [NUM_COINS];
  amt_t                  target;
  amt_t                  cnt;
  logic [COIN_CNT_W-1:0] coin_k;
  amt_t                  coin_sel;
  logic                  upd_valid;
  logic                  upd_fwd;
  amt_t                  upd_addr;
  entry_t                last_sum;
  entry_t                rd_hi;
  entry_t                rd_lo;
  entry_t                lo_op;
  logic [ENTRY_W-1:0]    raw_sum;
  entry_t                sum;
  logic                  we;
  amt_t                  waddr;
  entry_t                wdata;
  amt_t                  raddr_hi;
  amt_t                  raddr_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COINS; i++) begin
        coin[i] <= COIN_RESET[i];
      end
    end else if (cfg_write) begin
      coin[cfg_index] <= cfg_data;
    end
  end

  assign coin_sel = coin[coin_k[COIN_IDX_W-1:0]];

  assign sts.cnt_at_target = (cnt == target);
  assign sts.coin_done     = (coin_k == COIN_CNT_W'(NUM_COINS));
  assign sts.coin_skip     = (coin_sel == '0) || (coin_sel > target);

  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      target <= target_amount;
      cnt    <= '0;
      coin_k <= '0;
    end else begin
      if (cmd.clr_en || cmd.run_en) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.pass_init) begin
        cnt <= coin_sel;
      end
      if (cmd.next_coin) begin
        coin_k <= coin_k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
      upd_fwd   <= 1'b0;
    end else begin
      upd_valid <= cmd.run_en;
      // coin of one reads the entry written in the same cycle
      upd_fwd   <= cmd.run_en && (coin_sel == AMT_W'(1)) && upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr <= cnt;
    if (upd_valid) begin
      last_sum <= sum;
    end
  end

  assign raddr_hi = cmd.run_en ? cnt : target;
  assign raddr_lo = cnt - coin_sel;

  assign lo_op   = upd_fwd ? last_sum : rd_lo;
  assign raw_sum = {1'b0, rd_hi[COUNT_W-1:0]} + {1'b0, lo_op[COUNT_W-1:0]};

  always_comb begin
    if (rd_hi[ENTRY_W-1] || lo_op[ENTRY_W-1] || raw_sum[ENTRY_W-1]) begin
      sum = '1;
    end else begin
      sum = raw_sum;
    end
  end

  assign we    = cmd.clr_en || upd_valid;
  assign waddr = cmd.clr_en ? cnt : upd_addr;
  assign wdata = cmd.clr_en ? ((cnt == '0) ? ENTRY_W'(1) : '0) : sum;

  ccwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_hi (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_hi),
    .rdata (rd_hi)
  );

  ccwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_lo (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_lo),
    .rdata (rd_lo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      ways_count     <= rd_hi[COUNT_W-1:0];
      count_overflow <= rd_hi[ENTRY_W-1];
    end
  end

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_en && upd_valid))
    else $error("clear and update write in the same cycle");

  a_fwd_needs_update: assert property (@(posedge clk) disable iff (rst)
    upd_fwd |-> (upd_valid && $past(upd_valid)))
    else $error("forward without a preceding update");

endmodule

### hw/rtl/coin_change_way_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_change_way_counter
// Counts unordered ways to make a target amount from eight configurable coin
// denominations, with a 63-bit saturating count and overflow flag.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | target_amount[9:0]
//   out     | out_valid / out_ready| ways_count[62:0], count_overflow
//   cfg     | cfg_write            | cfg_index[2:0], cfg_data[9:0]
//
// One word runs a clear sweep over entries 0..T, then a select step per coin
// plus an update sweep over amounts c..T for each nonzero coin c <= T, then a
// fetch and a load of the result; one table update per cycle.
// The way table is two RAM copies for the two reads; no clearing after reset.
// A new word is taken only while idle; a pending result holds in its output
// register while the next word runs, and only the final load waits on it.
// ----------------------------------------------------------------------------
module coin_change_way_counter import ccwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [COIN_IDX_W-1:0] cfg_index,
  input  logic [AMT_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [AMT_W-1:0]      target_amount,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_W-1:0]    ways_count,
  output logic                  count_overflow
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ccwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccwc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .target_amount  (target_amount),
    .cmd            (cmd),
    .sts            (sts),
    .ways_count     (ways_count),
    .count_overflow (count_overflow)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the coin change way counter against a predictor that runs the same
// unbounded-knapsack count on its own copy of the coin registers. Directed
// targets and coin sets cover the edges. Random phases follow, with sender
// idling, receiver stalls, and one long output hold-off that backs up the
// input. Every result word is checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ccwc_pkg::*;

  localparam int LONG_HOLD = 3000;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } way_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [COIN_IDX_W-1:0] cfg_index = '0;
  logic [AMT_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [AMT_W-1:0]      target_amount = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_W-1:0]    ways_count;
  logic                  count_overflow;

  amt_t        coin_value [NUM_COINS];
  amt_t        pending_targets [$];
  way_result_t ways_expected [$];
  way_result_t head_result;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        long_hold_phase = 1'b0;
  int          held_cycles = 0;
  int          quiet_cycles = 0;
  int          errors = 0;

  coin_change_way_counter dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target_amount(target_amount),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ways_count(ways_count),
    .count_overflow(count_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Saturating way count; bit 63 of each entry is the sticky overflow mark.
  function automatic way_result_t count_ways(amt_t target);
    logic [ENTRY_W-1:0] ways [0:MAX_TARGET];
    logic [ENTRY_W-1:0] sum;
    way_result_t        res;
    int                 c;
    for (int a = 0; a <= MAX_TARGET; a++) ways[a] = '0;
    ways[0] = 64'd1;
    for (int k = 0; k < NUM_COINS; k++) begin
      c = coin_value[k];
      if (c != 0) begin
        for (int a = c; a <= target; a++) begin
          sum = {1'b0, ways[a][COUNT_W-1:0]} + {1'b0, ways[a-c][COUNT_W-1:0]};
          if (ways[a][ENTRY_W-1] || ways[a-c][ENTRY_W-1] || sum[ENTRY_W-1])
            ways[a] = '1;
          else
            ways[a] = sum;
        end
      end
    end
    res.count = ways[target][COUNT_W-1:0];
    res.overflow = ways[target][ENTRY_W-1];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ways_expected.push_back(count_ways(target_amount));
        void'(pending_targets.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          target_amount <= pending_targets[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ways_expected.size() == 0) begin
          $display("%0t: unexpected word, count %0d overflow %0b", $time, ways_count,
                   count_overflow);
          errors++;
        end else begin
          head_result = ways_expected.pop_front();
          if (ways_count !== head_result.count) begin
            $display("%0t: ways_count expected %0d actual %0d", $time, head_result.count,
                     ways_count);
            errors++;
          end
          if (count_overflow !== head_result.overflow) begin
            $display("%0t: count_overflow expected %0b actual %0b", $time,
                     head_result.overflow, count_overflow);
            errors++;
          end
        end
      end
      if (long_hold_phase && held_cycles < LONG_HOLD) begin
        out_ready <= 1'b0;
        held_cycles++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("coin_change_way_counter test failed");
      $finish;
    end
  end

  task automatic write_coin(int idx, int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx[COIN_IDX_W-1:0];
    cfg_data <= val[AMT_W-1:0];
    coin_value[idx] = val[AMT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic randomize_coins();
    int r;
    for (int k = 0; k < NUM_COINS; k++) begin
      r = $urandom_range(99);
      if (r < 8) write_coin(k, 0);
      else if (r < 60) write_coin(k, $urandom_range(1, 30));
      else if (r < 85) write_coin(k, $urandom_range(1, 200));
      else write_coin(k, $urandom_range(1, 1023));
    end
  endtask

  task automatic drain();
    while (pending_targets.size() > 0 || ways_expected.size() > 0) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 85) pending_targets.push_back(amt_t'($urandom_range(0, 63)));
      else if (r < 96) pending_targets.push_back(amt_t'($urandom_range(0, MAX_TARGET)));
      else pending_targets.push_back(amt_t'(MAX_TARGET));
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_COINS; k++) coin_value[k] = COIN_RESET[k];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset coin set, extremes and alternating bit patterns
    pending_targets = '{10'd0, 10'd1, 10'd2, 10'd5, 10'd10, 10'd199, 10'd200, 10'd341,
                        10'd682, 10'd1023};
    drain();

    // every coin 1023, at or above each target
    for (int k = 0; k < NUM_COINS; k++) write_coin(k, 1023);
    pending_targets = '{10'd0, 10'd1022, 10'd1023};
    drain();

    // zero coins skipped, equal coins each given their own pass
    write_coin(0, 0);
    write_coin(1, 3);
    write_coin(2, 0);
    write_coin(3, 7);
    write_coin(4, 3);
    write_coin(5, 3);
    write_coin(6, 1023);
    write_coin(7, 1);
    pending_targets = '{10'd0, 10'd1, 10'd6, 10'd9, 10'd1023};
    drain();

    // all coins one: largest count reachable
    for (int k = 0; k < NUM_COINS; k++) write_coin(k, 1);
    pending_targets = '{10'd1023, 10'd512};
    drain();

    for (int p = 0; p < 4; p++) begin
      if (p == 0) begin
        for (int k = 0; k < NUM_COINS; k++) write_coin(k, COIN_RESET[k]);
      end else begin
        randomize_coins();
      end
      @(posedge clk);
      send_idle_pct <= (p == 1) ? 53 : (p == 3) ? 33 : 0;
      recv_stall_pct <= (p == 2) ? 53 : (p == 3) ? 33 : 0;
      @(posedge clk);
      queue_random(22);
      drain();
    end

    // long output hold-off: the block fills up and stalls its input
    randomize_coins();
    @(posedge clk);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    long_hold_phase <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) pending_targets.push_back(amt_t'($urandom_range(0, 40)));
    drain();
    long_hold_phase <= 1'b0;

    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("coin_change_way_counter test passed");
    end else begin
      $display("coin_change_way_counter test failed");
    end
    $finish;
  end

endmodule
